// ===== rtl/ptss_pkg.sv =====
// shared types and codes for the periodic task slot scheduler
package ptss_pkg;

	// default number of task slots
	localparam int SLOTS_DEF = 4;

	// field widths
	localparam int OP_W     = 3;
	localparam int HANDLE_W = 8;
	localparam int PERIOD_W = 16;
	localparam int INDEX_W  = 8;
	localparam int FIRE_W   = 4;
	localparam int GRANT_W  = 2;
	localparam int MODE_W   = 2;
	localparam int ERR_W    = 3;

	// stream data widths, padded to whole bytes
	localparam int IN_DATA_W  = 40;
	localparam int OUT_DATA_W = 16;

	// opcodes
	localparam logic [OP_W-1:0] OP_INIT   = 3'd0;
	localparam logic [OP_W-1:0] OP_REG    = 3'd1;
	localparam logic [OP_W-1:0] OP_UNREG  = 3'd2;
	localparam logic [OP_W-1:0] OP_TICK   = 3'd3;
	localparam logic [OP_W-1:0] OP_STATUS = 3'd4;

	// operating modes
	localparam logic [MODE_W-1:0] MODE_UNINIT = 2'd0;
	localparam logic [MODE_W-1:0] MODE_READY  = 2'd1;
	localparam logic [MODE_W-1:0] MODE_ERROR  = 2'd2;

	// error codes
	localparam logic [ERR_W-1:0] ERR_NONE       = 3'd0;
	localparam logic [ERR_W-1:0] ERR_NOTINIT    = 3'd1;
	localparam logic [ERR_W-1:0] ERR_NULL       = 3'd2;
	localparam logic [ERR_W-1:0] ERR_ZEROPERIOD = 3'd3;
	localparam logic [ERR_W-1:0] ERR_DUP        = 3'd4;
	localparam logic [ERR_W-1:0] ERR_FULL       = 3'd5;
	localparam logic [ERR_W-1:0] ERR_BADID      = 3'd6;

	// one slot table entry
	typedef struct packed {
		logic [PERIOD_W-1:0] count;
		logic [PERIOD_W-1:0] period;
		logic [HANDLE_W-1:0] handle;
	} slot_entry_t;

	// control strobes from sequencer to slot table
	typedef struct packed {
		logic rd_en;
		logic wr_en;
		logic set_valid;
		logic clr_one;
		logic clr_all;
	} mem_ctl_t;

	// one result item
	typedef struct packed {
		logic [ERR_W-1:0]   error_code;
		logic [MODE_W-1:0]  mode_now;
		logic [GRANT_W-1:0] slot_granted;
		logic               reply_ok;
		logic [FIRE_W-1:0]  fire_mask;
	} result_t;

endpackage

// ===== rtl/ptss_slot_mem.sv =====
// slot table memory with per-slot occupied bits
module ptss_slot_mem
	import ptss_pkg::*;
#(
	parameter int SLOTS = SLOTS_DEF,
	parameter int IDX_W = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  mem_ctl_t         ctl,
	input  logic [IDX_W-1:0] rd_addr,
	input  logic [IDX_W-1:0] wr_addr,
	input  slot_entry_t      wr_data,
	input  logic [IDX_W-1:0] clr_addr,
	output slot_entry_t      rd_data,
	output logic [SLOTS-1:0] occupied
);

	slot_entry_t      mem [SLOTS];
	slot_entry_t      rd_data_q;
	logic [SLOTS-1:0] valid_q;

	// occupied bits, cleared at once by reset or init
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (ctl.clr_all) begin
			valid_q <= '0;
		end else begin
			if (ctl.clr_one) begin
				valid_q[clr_addr] <= 1'b0;
			end
			if (ctl.wr_en && ctl.set_valid) begin
				valid_q[wr_addr] <= 1'b1;
			end
		end
	end

	// entry storage, one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (ctl.rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data  = rd_data_q;
	assign occupied = valid_q;

endmodule

// ===== rtl/ptss_ctrl.sv =====
// command sequencer: decodes items and walks the slot table
module ptss_ctrl
	import ptss_pkg::*;
#(
	parameter int SLOTS = SLOTS_DEF,
	parameter int IDX_W = 2
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [OP_W-1:0]     opcode,
	input  logic [HANDLE_W-1:0] task_handle,
	input  logic [PERIOD_W-1:0] task_period,
	input  logic [INDEX_W-1:0]  slot_index,
	output logic                res_valid,
	input  logic                res_ready,
	output result_t             res,
	output mem_ctl_t            mem_ctl,
	output logic [IDX_W-1:0]    rd_addr,
	output logic [IDX_W-1:0]    wr_addr,
	output slot_entry_t         wr_data,
	output logic [IDX_W-1:0]    clr_addr,
	input  slot_entry_t         rd_data,
	input  logic [SLOTS-1:0]    occupied
);

	localparam int CNT_W = $clog2(SLOTS + 1);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_WALK = 3'b010,
		ST_DONE = 3'b100
	} state_t;

	state_t              state_q, state_d;
	logic [MODE_W-1:0]   mode_q, mode_d;
	logic [ERR_W-1:0]    last_err_q, last_err_d;
	logic [OP_W-1:0]     op_q, op_d;
	logic [HANDLE_W-1:0] handle_q, handle_d;
	logic [PERIOD_W-1:0] period_q, period_d;
	logic [CNT_W-1:0]    rd_cnt_q, rd_cnt_d;
	logic                v_s1, v_s1_d;
	logic [IDX_W-1:0]    idx_s1, idx_s1_d;
	logic                dup_q, dup_d;
	logic [FIRE_W-1:0]   fire_q, fire_d;
	logic [IDX_W-1:0]    free_idx_q, free_idx_d;
	logic                full_q, full_d;
	result_t             res_q, res_d;

	// lowest free slot and full flag from occupied bits
	logic [IDX_W-1:0] free_idx;
	logic             table_full;
	always_comb begin
		free_idx = '0;
		for (int i = SLOTS - 1; i >= 0; i--) begin
			if (!occupied[i]) begin
				free_idx = IDX_W'(i);
			end
		end
		table_full = &occupied;
	end

	// per-slot values for the entry returned by the read port
	logic                occ_s1;
	logic [PERIOD_W-1:0] cnt_inc;
	logic                hits_period;
	logic                is_last;
	logic [FIRE_W-1:0]   fire_bit;
	always_comb begin
		occ_s1      = occupied[idx_s1];
		cnt_inc     = rd_data.count + 1'b1;
		hits_period = cnt_inc >= rd_data.period;
		is_last     = idx_s1 == IDX_W'(SLOTS - 1);
		fire_bit    = '0;
		for (int j = 0; j < FIRE_W; j++) begin
			if (32'(idx_s1) == j) begin
				fire_bit[j] = occ_s1 && hits_period;
			end
		end
	end

	// next-state logic
	always_comb begin
		state_d    = state_q;
		mode_d     = mode_q;
		last_err_d = last_err_q;
		op_d       = op_q;
		handle_d   = handle_q;
		period_d   = period_q;
		rd_cnt_d   = rd_cnt_q;
		v_s1_d     = 1'b0;
		idx_s1_d   = idx_s1;
		dup_d      = dup_q;
		fire_d     = fire_q;
		free_idx_d = free_idx_q;
		full_d     = full_q;
		res_d      = res_q;
		mem_ctl    = '0;
		rd_addr    = rd_cnt_q[IDX_W-1:0];
		wr_addr    = idx_s1;
		wr_data    = rd_data;
		clr_addr   = slot_index[IDX_W-1:0];

		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					op_d       = opcode;
					handle_d   = task_handle;
					period_d   = task_period;
					rd_cnt_d   = '0;
					dup_d      = 1'b0;
					fire_d     = '0;
					free_idx_d = free_idx;
					full_d     = table_full;
					res_d      = '0;
					state_d    = ST_DONE;
					unique case (opcode)
						OP_INIT: begin
							mem_ctl.clr_all = 1'b1;
							last_err_d      = ERR_NONE;
							mode_d          = MODE_READY;
						end
						OP_REG: begin
							if (mode_q == MODE_UNINIT) begin
								last_err_d = ERR_NOTINIT;
								mode_d     = MODE_ERROR;
							end else if (task_handle == '0) begin
								last_err_d = ERR_NULL;
								mode_d     = MODE_ERROR;
							end else if (task_period == '0) begin
								last_err_d = ERR_ZEROPERIOD;
								mode_d     = MODE_ERROR;
							end else begin
								state_d = ST_WALK;
							end
						end
						OP_UNREG: begin
							if (slot_index >= INDEX_W'(SLOTS)) begin
								last_err_d = ERR_BADID;
							end else if (occupied[slot_index[IDX_W-1:0]]) begin
								mem_ctl.clr_one = 1'b1;
								res_d.reply_ok  = 1'b1;
							end
						end
						OP_TICK: begin
							if (mode_q != MODE_UNINIT) begin
								state_d = ST_WALK;
							end
						end
						OP_STATUS: begin
							res_d.error_code = last_err_q;
							last_err_d       = ERR_NONE;
						end
						default: begin
						end
					endcase
				end
			end

			ST_WALK: begin
				// issue one read per cycle until every slot is requested
				if (rd_cnt_q < CNT_W'(SLOTS)) begin
					mem_ctl.rd_en = 1'b1;
					rd_cnt_d      = rd_cnt_q + 1'b1;
					v_s1_d        = 1'b1;
					idx_s1_d      = rd_cnt_q[IDX_W-1:0];
				end
				// process the entry read in the previous cycle; the write goes to
				// the entry just read while the read port moves on to the next one
				if (v_s1) begin
					if (op_q == OP_TICK) begin
						if (occ_s1) begin
							mem_ctl.wr_en = 1'b1;
							wr_data.count = hits_period ? '0 : cnt_inc;
						end
						fire_d = fire_q | fire_bit;
					end else begin
						dup_d = dup_q | (occ_s1 && rd_data.handle == handle_q);
					end
					if (is_last) begin
						state_d = ST_DONE;
						res_d.fire_mask = fire_d;
						if (op_q == OP_REG) begin
							if (dup_d) begin
								last_err_d = ERR_DUP;
								mode_d     = MODE_ERROR;
							end else if (full_q) begin
								last_err_d = ERR_FULL;
								mode_d     = MODE_ERROR;
							end else begin
								mem_ctl.wr_en      = 1'b1;
								mem_ctl.set_valid  = 1'b1;
								wr_addr            = free_idx_q;
								wr_data.handle     = handle_q;
								wr_data.period     = period_q;
								wr_data.count      = '0;
								res_d.reply_ok     = 1'b1;
								res_d.slot_granted = GRANT_W'(free_idx_q);
							end
						end
					end
				end
			end

			ST_DONE: begin
				if (res_ready) begin
					state_d = ST_IDLE;
				end
			end

			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			mode_q     <= MODE_UNINIT;
			last_err_q <= ERR_NONE;
			rd_cnt_q   <= '0;
			v_s1       <= 1'b0;
		end else begin
			state_q    <= state_d;
			mode_q     <= mode_d;
			last_err_q <= last_err_d;
			rd_cnt_q   <= rd_cnt_d;
			v_s1       <= v_s1_d;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		op_q       <= op_d;
		handle_q   <= handle_d;
		period_q   <= period_d;
		idx_s1     <= idx_s1_d;
		dup_q      <= dup_d;
		fire_q     <= fire_d;
		free_idx_q <= free_idx_d;
		full_q     <= full_d;
		res_q      <= res_d;
	end

	// result carries the mode left by this item
	always_comb begin
		res          = res_q;
		res.mode_now = mode_q;
	end

	assign in_ready  = state_q == ST_IDLE;
	assign res_valid = state_q == ST_DONE;

endmodule

// ===== rtl/periodic_task_slot_scheduler.sv =====
// top level of the periodic task slot scheduler
//
// Usage: one command per input transfer on the s_ stream, one result per
// command on the m_ stream, in order. Commands are init, register,
// unregister, tick and read_status; the task slots (handle, period, counter)
// live in a small synchronous memory with one read and one write port, and
// an occupied bit per slot in flip-flops.
// Direct results: init, unregister, read_status, unknown codes, early
// register failures and ticks before init pass from the sequencer's result
// register to the output register. Register and tick first walk the slot
// table through the memory read port, one slot per cycle.
// Flow: one command at a time; the next input is taken once the
// previous result has moved into the output register.
// Reset: mode uninit, last error none, every slot empty at once; no
// clearing pass is needed.
// Stall: the output register holds the result while m_tready is low; one
// further result waits inside and input is refused until it moves on.
module periodic_task_slot_scheduler
	import ptss_pkg::*;
#(
	parameter int SLOTS = SLOTS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// opcode, task_handle, task_period, slot_index, zero pad
	input  logic [IN_DATA_W-1:0]  s_tdata,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// fire_mask, reply_ok, slot_granted, mode_now, error_code, zero pad
	output logic [OUT_DATA_W-1:0] m_tdata
);

	localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

	// input field unpacking
	logic [OP_W-1:0]     opcode;
	logic [HANDLE_W-1:0] task_handle;
	logic [PERIOD_W-1:0] task_period;
	logic [INDEX_W-1:0]  slot_index;
	assign opcode      = s_tdata[2:0];
	assign task_handle = s_tdata[10:3];
	assign task_period = s_tdata[26:11];
	assign slot_index  = s_tdata[34:27];

	mem_ctl_t         mem_ctl;
	logic [IDX_W-1:0] rd_addr;
	logic [IDX_W-1:0] wr_addr;
	logic [IDX_W-1:0] clr_addr;
	slot_entry_t      wr_data;
	slot_entry_t      rd_data;
	logic [SLOTS-1:0] occupied;
	logic             res_valid;
	logic             res_ready;
	result_t          res;

	ptss_ctrl #(
		.SLOTS(SLOTS),
		.IDX_W(IDX_W)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.opcode     (opcode),
		.task_handle(task_handle),
		.task_period(task_period),
		.slot_index (slot_index),
		.res_valid  (res_valid),
		.res_ready  (res_ready),
		.res        (res),
		.mem_ctl    (mem_ctl),
		.rd_addr    (rd_addr),
		.wr_addr    (wr_addr),
		.wr_data    (wr_data),
		.clr_addr   (clr_addr),
		.rd_data    (rd_data),
		.occupied   (occupied)
	);

	ptss_slot_mem #(
		.SLOTS(SLOTS),
		.IDX_W(IDX_W)
	) u_slot_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (mem_ctl),
		.rd_addr (rd_addr),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.clr_addr(clr_addr),
		.rd_data (rd_data),
		.occupied(occupied)
	);

	// output register
	logic    out_valid_q;
	result_t out_q;

	assign res_ready = !out_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			out_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {(OUT_DATA_W - $bits(result_t))'(0), out_q};

endmodule
